/* sv/dosc_pkg.sv */
// Shared types and constants of the output command scheduler.
`default_nettype none

package dosc_pkg;

   // Table size and field widths
   localparam int NUM_CHANNELS = 8;
   localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int IDX_W        = 4;
   localparam int CHB_W        = 5;
   localparam int FREQ_W       = 32;
   localparam int DUTY_W       = 16;
   localparam int CODE_W       = 8;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   // Operation codes of an input transaction
   typedef enum logic [1:0] {
      OP_SET  = 2'd0,
      OP_POLL = 2'd1,
      OP_ACK  = 2'd2
   } op_type;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      REG_SET_CODE     = 2'd0,
      REG_DISABLE_CODE = 2'd1,
      REG_OK_CODE      = 2'd2,
      REG_DUTY_LIMIT   = 2'd3
   } reg_type;

   typedef struct packed {
      logic [CODE_W-1:0] set_code;
      logic [CODE_W-1:0] disable_code;
      logic [CODE_W-1:0] ok_code;
      logic [DUTY_W-1:0] duty_limit;
   } cfg_type;

   // Classified command as it travels from front to back
   typedef struct packed {
      op_type            op;
      logic [CH_W-1:0]   idx;
      logic              enable;
      logic [FREQ_W-1:0] freq;
      logic [DUTY_W-1:0] duty;
      logic              ack_fail;
   } cmd_type;

   // One set of output values (wanted or last sent)
   typedef struct packed {
      logic              enable;
      logic [FREQ_W-1:0] freq;
      logic [DUTY_W-1:0] duty;
   } setting_type;

   typedef struct packed {
      logic              found;
      logic              kind;
      logic [CODE_W-1:0] command;
      logic [CHB_W-1:0]  channel;
      logic [FREQ_W-1:0] freq;
      logic [DUTY_W-1:0] duty;
      logic [IDX_W-1:0]  index;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/dosc_front.sv */
// Front end: accepts input transactions, drops ignored ones, clamps duty.
`default_nettype none

module dosc_front (
   input  wire dosc_pkg::cfg_type            cfg,
   input  wire                               start,
   input  wire [1:0]                         req_operation,
   input  wire [dosc_pkg::IDX_W-1:0]         req_channel_index,
   input  wire                               req_enable,
   input  wire [dosc_pkg::FREQ_W-1:0]        req_frequency_hz,
   input  wire [dosc_pkg::DUTY_W-1:0]        req_duty,
   input  wire [dosc_pkg::CODE_W-1:0]        req_ack_result,
   input  wire                               queue_full,
   output logic                              busy,
   output logic                              push,
   output dosc_pkg::cmd_type                 cmd
);

   logic accept;
   logic in_range;
   logic keep;

   assign busy   = queue_full;
   assign accept = start && !queue_full;
   assign in_range = {1'b0, req_channel_index} < (dosc_pkg::IDX_W + 1)'(dosc_pkg::NUM_CHANNELS);

   // Classify: set and acknowledge need a valid entry, unknown codes are dropped
   always_comb begin
      case (dosc_pkg::op_type'(req_operation))
         dosc_pkg::OP_SET:  keep = in_range;
         dosc_pkg::OP_POLL: keep = 1'b1;
         dosc_pkg::OP_ACK:  keep = in_range;
         default:           keep = 1'b0;
      endcase
   end

   assign push = accept && keep;

   // Build the queued command, clamp duty and resolve the acknowledge result
   always_comb begin
      cmd.op       = dosc_pkg::op_type'(req_operation);
      cmd.idx      = req_channel_index[dosc_pkg::CH_W-1:0];
      cmd.enable   = req_enable;
      cmd.freq     = req_frequency_hz;
      cmd.duty     = (req_duty > cfg.duty_limit) ? cfg.duty_limit : req_duty;
      cmd.ack_fail = (req_ack_result != cfg.ok_code);
   end

endmodule

`default_nettype wire

/* sv/dosc_fifo.sv */
// Two-entry command queue between front end and back end.
`default_nettype none

module dosc_fifo (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  wire dosc_pkg::cmd_type din,
   input  wire                pop,
   output dosc_pkg::cmd_type  dout,
   output logic               full,
   output logic               empty
);

   localparam int DEPTH = 2;
   localparam int PTR_W = 1;

   dosc_pkg::cmd_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]          count_ff, count_in;

   assign full  = (count_ff == (PTR_W + 1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = mem_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

/* sv/dosc_back.sv */
// Back end: channel table, dirty scan and command frame generation.
`default_nettype none

module dosc_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire dosc_pkg::cfg_type cfg,
   input  wire                    empty,
   input  wire dosc_pkg::cmd_type cmd,
   output logic                   pop,
   output logic                   rsp_strobe,
   output dosc_pkg::rsp_type      rsp
);

   typedef enum logic {ST_FETCH, ST_EXEC} state_type;

   localparam int N = dosc_pkg::NUM_CHANNELS;

   state_type                  state_ff;
   dosc_pkg::cmd_type          cmd_ff;
   logic [dosc_pkg::CH_W-1:0]  addr_ff;
   logic                       found_ff;
   dosc_pkg::setting_type      want_row_ff;
   dosc_pkg::setting_type      sent_row_ff;
   logic                       strobe_ff;
   dosc_pkg::rsp_type          rsp_ff, rsp_in;

   dosc_pkg::setting_type      want_ff [N];
   dosc_pkg::setting_type      sent_ff [N];
   logic [N-1:0]               dirty_ff;
   logic [N-1:0]               await_ff;

   logic [N-1:0]               eligible;
   logic [dosc_pkg::CH_W-1:0]  pick;
   logic                       any;
   logic [dosc_pkg::CH_W-1:0]  addr;
   dosc_pkg::setting_type      new_want;

   // Lowest entry that is dirty and not awaiting an acknowledge
   always_comb begin
      eligible = dirty_ff & ~await_ff;
      any      = |eligible;
      pick     = '0;
      for (int c = N - 1; c >= 0; c--) begin
         if (eligible[c]) begin
            pick = dosc_pkg::CH_W'(c);
         end
      end
   end

   assign pop  = (state_ff == ST_FETCH) && !empty;
   assign addr = (cmd.op == dosc_pkg::OP_POLL) ? pick : cmd.idx;

   // Build the result frame of a poll
   always_comb begin
      rsp_in = '0;
      if (found_ff) begin
         rsp_in.found   = 1'b1;
         rsp_in.channel = dosc_pkg::CHB_W'(addr_ff) + dosc_pkg::CHB_W'(1);
         rsp_in.index   = dosc_pkg::IDX_W'(addr_ff);
         if (want_row_ff.enable) begin
            rsp_in.kind    = 1'b0;
            rsp_in.command = cfg.set_code;
            rsp_in.freq    = want_row_ff.freq;
            rsp_in.duty    = want_row_ff.duty;
         end else begin
            rsp_in.kind    = 1'b1;
            rsp_in.command = cfg.disable_code;
         end
      end
   end

   // Sequence: fetch and read the row, then execute and update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_FETCH;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_FETCH: begin
               if (!empty) begin
                  cmd_ff      <= cmd;
                  addr_ff     <= addr;
                  found_ff    <= any;
                  want_row_ff <= want_ff[addr];
                  sent_row_ff <= sent_ff[addr];
                  state_ff    <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (cmd_ff.op == dosc_pkg::OP_POLL) begin
                  strobe_ff <= 1'b1;
                  rsp_ff    <= rsp_in;
               end
               state_ff <= ST_FETCH;
            end
            default: state_ff <= ST_FETCH;
         endcase
      end
   end

   assign new_want = '{enable: cmd_ff.enable, freq: cmd_ff.freq, duty: cmd_ff.duty};

   // Update the channel table
   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= '0;
         await_ff <= '0;
         for (int c = 0; c < N; c++) begin
            want_ff[c] <= '0;
            sent_ff[c] <= '0;
         end
      end else if (state_ff == ST_EXEC) begin
         case (cmd_ff.op)
            dosc_pkg::OP_SET: begin
               want_ff[addr_ff] <= new_want;
               if (new_want != want_row_ff) begin
                  dirty_ff[addr_ff] <= 1'b1;
               end
            end
            dosc_pkg::OP_ACK: begin
               await_ff[addr_ff] <= 1'b0;
               dirty_ff[addr_ff] <= cmd_ff.ack_fail || (want_row_ff != sent_row_ff);
            end
            dosc_pkg::OP_POLL: begin
               if (found_ff) begin
                  await_ff[addr_ff] <= 1'b1;
                  sent_ff[addr_ff]  <= want_row_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule

`default_nettype wire

/* sv/dirty_output_command_scheduler.sv */
// Top level of the output command scheduler: register port, queue, front and back ends.
`default_nettype none

// Keeps an eight-entry table of output channels and issues one command frame per poll
// for the lowest dirty channel not awaiting an acknowledge. A transaction is taken when
// start is high and busy is low; busy rises only while the two-entry queue is full.
// The back end handles each transaction in a table read state (ST_FETCH) and then an
// update state (ST_EXEC), and takes no new transaction until the last one is through.
// Poll results appear on the rsp_ ports for one cycle, marked by rsp_strobe, and are
// registered at the end of the update state; the receiver must take them as they come.
// Set and acknowledge transactions with an out-of-range channel, and unknown
// operations, are dropped at the front and give no result.
module dirty_output_command_scheduler (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire [1:0]                        req_operation,
   input  wire [dosc_pkg::IDX_W-1:0]        req_channel_index,
   input  wire                              req_enable,
   input  wire [dosc_pkg::FREQ_W-1:0]       req_frequency_hz,
   input  wire [dosc_pkg::DUTY_W-1:0]       req_duty,
   input  wire [dosc_pkg::CODE_W-1:0]       req_ack_result,
   output logic                             rsp_strobe,
   output logic                             rsp_found,
   output logic                             rsp_request_kind,
   output logic [dosc_pkg::CODE_W-1:0]      rsp_command_byte,
   output logic [dosc_pkg::CHB_W-1:0]       rsp_channel_byte,
   output logic [dosc_pkg::FREQ_W-1:0]      rsp_sent_frequency,
   output logic [dosc_pkg::DUTY_W-1:0]      rsp_sent_duty_value,
   output logic [dosc_pkg::IDX_W-1:0]       rsp_request_index,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire [dosc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire [dosc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [dosc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   dosc_pkg::cfg_type  cfg_ff;
   dosc_pkg::reg_type  reg_sel;
   logic               csr_write;
   logic               push;
   logic               pop;
   logic               queue_full;
   logic               queue_empty;
   dosc_pkg::cmd_type  push_cmd;
   dosc_pkg::cmd_type  head_cmd;
   dosc_pkg::rsp_type  rsp;

   assign pready    = 1'b1;
   assign reg_sel   = dosc_pkg::reg_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_code     <= 8'd1;
         cfg_ff.disable_code <= 8'd2;
         cfg_ff.ok_code      <= 8'd0;
         cfg_ff.duty_limit   <= 16'd10000;
      end else if (csr_write) begin
         case (reg_sel)
            dosc_pkg::REG_SET_CODE:     cfg_ff.set_code     <= pwdata[7:0];
            dosc_pkg::REG_DISABLE_CODE: cfg_ff.disable_code <= pwdata[7:0];
            dosc_pkg::REG_OK_CODE:      cfg_ff.ok_code      <= pwdata[7:0];
            dosc_pkg::REG_DUTY_LIMIT:   cfg_ff.duty_limit   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Return register contents on read
   always_comb begin
      case (reg_sel)
         dosc_pkg::REG_SET_CODE:     prdata = {24'd0, cfg_ff.set_code};
         dosc_pkg::REG_DISABLE_CODE: prdata = {24'd0, cfg_ff.disable_code};
         dosc_pkg::REG_OK_CODE:      prdata = {24'd0, cfg_ff.ok_code};
         dosc_pkg::REG_DUTY_LIMIT:   prdata = {16'd0, cfg_ff.duty_limit};
         default:                    prdata = '0;
      endcase
   end

   dosc_front u_front (
      .cfg               (cfg_ff),
      .start             (start),
      .req_operation     (req_operation),
      .req_channel_index (req_channel_index),
      .req_enable        (req_enable),
      .req_frequency_hz  (req_frequency_hz),
      .req_duty          (req_duty),
      .req_ack_result    (req_ack_result),
      .queue_full        (queue_full),
      .busy              (busy),
      .push              (push),
      .cmd               (push_cmd)
   );

   dosc_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (push_cmd),
      .pop   (pop),
      .dout  (head_cmd),
      .full  (queue_full),
      .empty (queue_empty)
   );

   dosc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .empty      (queue_empty),
      .cmd        (head_cmd),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   assign rsp_found           = rsp.found;
   assign rsp_request_kind    = rsp.kind;
   assign rsp_command_byte    = rsp.command;
   assign rsp_channel_byte    = rsp.channel;
   assign rsp_sent_frequency  = rsp.freq;
   assign rsp_sent_duty_value = rsp.duty;
   assign rsp_request_index   = rsp.index;

   // Back end passes through a fetch state between executions, so results never come back to back
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe in consecutive cycles");

   // Empty poll returns an all-zero frame
   a_empty_poll_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_found |-> rsp_command_byte == '0 && rsp_channel_byte == '0 &&
         rsp_sent_frequency == '0 && rsp_sent_duty_value == '0 && rsp_request_index == '0)
      else $error("empty poll with nonzero fields");

   // Channel byte is the entry index plus one
   a_channel_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_found |->
         rsp_channel_byte == {1'b0, rsp_request_index} + 5'd1)
      else $error("channel byte does not match request index");

   // Disable frames carry no frequency or duty
   a_disable_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_found && rsp_request_kind |->
         rsp_sent_frequency == '0 && rsp_sent_duty_value == '0)
      else $error("disable frame with payload");

endmodule

`default_nettype wire
